>>> rtl/kau_pkg.sv
// Package with the shared constants and types of the k-means assign and update block.
package kau_pkg;

    localparam int MAX_CLUSTERS = 8;
    localparam int COORD_BITS   = 16;
    localparam int FRAC_BITS    = 8;
    localparam int COUNT_BITS   = 20;
    localparam int CENT_BITS    = COORD_BITS + FRAC_BITS;
    localparam int SUM_BITS     = COORD_BITS + COUNT_BITS;
    localparam int IDX_BITS     = $clog2(MAX_CLUSTERS);
    localparam int NUM_BITS     = SUM_BITS + FRAC_BITS;
    localparam int DIFF_BITS    = CENT_BITS + 1;
    localparam int DIST_BITS    = 2 * DIFF_BITS + 1;
    localparam int DIV_CNT_BITS = $clog2(NUM_BITS + 1);

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_ASSIGN = 2'd1;
    localparam logic [1:0] MODE_UPDATE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST_X,
        ST_DIST_Y,
        ST_COMPARE,
        ST_ACCUM,
        ST_UPD_START,
        ST_DIV,
        ST_UPD_WRITE,
        ST_OUT
    } kau_state_t;

endpackage

>>> rtl/kmeans_assign_update.sv
// Top level of the two-dimensional k-means assign and update block.
// Usage:
// The input channel (in_valid/in_ready) carries one word of mode, slot and
// coordinates. Mode 0 loads a centroid from integer coordinates and gives no
// result. Mode 1 assigns a point to the nearest active centroid, adds it to
// that cluster's sums and reports the cluster index (kind 0). Mode 2 ends
// the pass: each nonempty cluster's centroid becomes its mean with 8
// fraction bits, sums and counts are cleared, and one word with kind 1
// tells whether any centroid moved. Mode 3 is dropped.
// An assignment computes its distances on the one shared squaring
// multiplier, which serves x and y in turn. A pass end runs the shared
// restoring divider on each axis of every nonempty cluster, one quotient
// bit per cycle, and checks every slot in turn.
// The result waits in an output register; while it is not taken the block
// accepts no new word. in_ready is low while a word is at work.
// Reset clears all centroids, sums and counts and sets active_clusters to 4.
// cfg_we writes active_clusters and is only to be used while the block is
// idle; the user must keep to this, as the block itself does not enforce it.
module kmeans_assign_update
    import kau_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [3:0]                     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     mode,
    input  logic [2:0]                     slot,
    input  logic signed [COORD_BITS-1:0]   coord_x,
    input  logic signed [COORD_BITS-1:0]   coord_y,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           kind,
    output logic [2:0]                     nearest_id,
    output logic                           moved
);

    kau_state_t state_reg, state_next;

    logic [3:0]                        active_reg;
    logic signed [CENT_BITS-1:0]       cx_reg [MAX_CLUSTERS];
    logic signed [CENT_BITS-1:0]       cy_reg [MAX_CLUSTERS];
    logic signed [SUM_BITS-1:0]        sx_reg [MAX_CLUSTERS];
    logic signed [SUM_BITS-1:0]        sy_reg [MAX_CLUSTERS];
    logic [COUNT_BITS-1:0]             cnt_reg [MAX_CLUSTERS];

    logic signed [COORD_BITS-1:0]      px_reg, py_reg;
    logic [IDX_BITS-1:0]               idx_reg;
    logic [IDX_BITS-1:0]               best_reg;
    logic [DIST_BITS-1:0]              best_d_reg;
    logic [DIST_BITS-1:0]              dacc_reg;
    logic                              moved_reg;
    logic                              axis_reg;
    logic [IDX_BITS:0]                 n_eff;

    // Divider registers.
    logic [NUM_BITS-1:0]               dnum_reg;
    logic [COUNT_BITS:0]               drem_reg;
    logic [DIV_CNT_BITS-1:0]           dcnt_reg;
    logic                              dneg_reg;
    logic signed [CENT_BITS-1:0]       nx_reg;

    logic                              out_valid_reg;
    logic                              kind_reg;
    logic [2:0]                        id_reg;
    logic                              mv_reg;

    logic signed [DIFF_BITS-1:0]       diff;
    logic [DIFF_BITS-1:0]              diff_mag;
    logic [2*DIFF_BITS-1:0]            sq;
    logic [DIST_BITS-1:0]              dsum;
    logic [COUNT_BITS:0]               rem_shift;
    logic [COUNT_BITS:0]               rem_sub;
    logic                              rem_ge;
    logic [NUM_BITS-1:0]               q_signed;
    logic signed [CENT_BITS-1:0]       q_cent;
    logic                              last_idx;
    logic signed [SUM_BITS-1:0]        sel_sum;

    // Effective number of clusters taking part in the search.
    always_comb
    begin
        if (active_reg == 4'd0)
            n_eff = (IDX_BITS+1)'(1);
        else if (32'(active_reg) > MAX_CLUSTERS)
            n_eff = (IDX_BITS+1)'(MAX_CLUSTERS);
        else
            n_eff = (IDX_BITS+1)'(active_reg);
    end

    // Shared difference and squaring unit, one axis per cycle.
    always_comb
    begin
        if (!axis_reg)
            diff = DIFF_BITS'({{(DIFF_BITS-CENT_BITS){px_reg[COORD_BITS-1]}}, px_reg,
                   {FRAC_BITS{1'b0}}}) - DIFF_BITS'(cx_reg[idx_reg]);
        else
            diff = DIFF_BITS'({{(DIFF_BITS-CENT_BITS){py_reg[COORD_BITS-1]}}, py_reg,
                   {FRAC_BITS{1'b0}}}) - DIFF_BITS'(cy_reg[idx_reg]);
        diff_mag = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
        sq       = diff_mag * diff_mag;
        dsum     = dacc_reg + DIST_BITS'(sq);
    end

    // Shared restoring divider step.
    always_comb
    begin
        rem_shift = {drem_reg[COUNT_BITS-1:0], dnum_reg[NUM_BITS-1]};
        rem_ge    = rem_shift >= {1'b0, cnt_reg[idx_reg]};
        rem_sub   = rem_ge ? rem_shift - {1'b0, cnt_reg[idx_reg]} : rem_shift;
        q_signed  = dneg_reg ? NUM_BITS'(-dnum_reg) : dnum_reg;
        q_cent    = q_signed[CENT_BITS-1:0];
        last_idx  = (32'(idx_reg) == MAX_CLUSTERS - 1);
        sel_sum   = axis_reg ? sy_reg[idx_reg] : sx_reg[idx_reg];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (mode == MODE_ASSIGN)
                        state_next = ST_DIST_X;
                    else if (mode == MODE_UPDATE)
                        state_next = ST_UPD_START;
                end
            end
            ST_DIST_X:    state_next = ST_DIST_Y;
            ST_DIST_Y:    state_next = ST_COMPARE;
            ST_COMPARE:
                state_next = ((IDX_BITS+1)'(idx_reg) + 1'b1 >= n_eff) ? ST_ACCUM : ST_DIST_X;
            ST_ACCUM:     state_next = ST_OUT;
            ST_UPD_START:
                state_next = (cnt_reg[idx_reg] != '0) ? ST_DIV :
                             (last_idx ? ST_OUT : ST_UPD_START);
            ST_DIV:
                state_next = (dcnt_reg == DIV_CNT_BITS'(NUM_BITS)) ? ST_UPD_WRITE : ST_DIV;
            ST_UPD_WRITE:
                state_next = !axis_reg ? ST_DIV : (last_idx ? ST_OUT : ST_UPD_START);
            ST_OUT:
                state_next = (out_valid_reg && !out_ready) ? ST_OUT : ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE) && !out_valid_reg;
        out_valid  = out_valid_reg;
        kind       = kind_reg;
        nearest_id = id_reg;
        moved      = mv_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= 4'd4;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            axis_reg      <= 1'b0;
            dcnt_reg      <= '0;
            moved_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                active_reg <= cfg_data;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    idx_reg   <= '0;
                    axis_reg  <= 1'b0;
                    moved_reg <= 1'b0;
                end
                ST_DIST_X:    axis_reg <= 1'b1;
                ST_DIST_Y:    axis_reg <= 1'b0;
                ST_COMPARE:   idx_reg <= idx_reg + 1'b1;
                ST_UPD_START:
                begin
                    axis_reg <= 1'b0;
                    dcnt_reg <= '0;
                    if (cnt_reg[idx_reg] == '0)
                        idx_reg <= idx_reg + 1'b1;
                end
                ST_DIV:       dcnt_reg <= dcnt_reg + 1'b1;
                ST_UPD_WRITE:
                begin
                    dcnt_reg <= '0;
                    axis_reg <= !axis_reg;
                    if (axis_reg)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        if (nx_reg != cx_reg[idx_reg] || q_cent != cy_reg[idx_reg])
                            moved_reg <= 1'b1;
                    end
                end
                ST_ACCUM:     out_valid_reg <= 1'b1;
                ST_OUT:       ;
                default:      ;
            endcase
            if (state_reg == ST_UPD_START && state_next == ST_OUT)
                out_valid_reg <= 1'b1;
            if (state_reg == ST_UPD_WRITE && state_next == ST_OUT)
                out_valid_reg <= 1'b1;
        end
    end

    // Cluster state, cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CLUSTERS; i++)
            begin
                cx_reg[i]  <= '0;
                cy_reg[i]  <= '0;
                sx_reg[i]  <= '0;
                sy_reg[i]  <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (state_reg == ST_IDLE && in_valid && in_ready && mode == MODE_LOAD
                && 32'(slot) < MAX_CLUSTERS)
            begin
                cx_reg[slot[IDX_BITS-1:0]] <= {coord_x, {FRAC_BITS{1'b0}}};
                cy_reg[slot[IDX_BITS-1:0]] <= {coord_y, {FRAC_BITS{1'b0}}};
            end
            if (state_reg == ST_ACCUM && cnt_reg[best_reg] != {COUNT_BITS{1'b1}})
            begin
                sx_reg[best_reg]  <= sx_reg[best_reg] + SUM_BITS'(px_reg);
                sy_reg[best_reg]  <= sy_reg[best_reg] + SUM_BITS'(py_reg);
                cnt_reg[best_reg] <= cnt_reg[best_reg] + 1'b1;
            end
            if (state_reg == ST_UPD_START && cnt_reg[idx_reg] == '0)
            begin
                sx_reg[idx_reg] <= '0;
                sy_reg[idx_reg] <= '0;
            end
            if (state_reg == ST_UPD_WRITE && axis_reg)
            begin
                cx_reg[idx_reg]  <= nx_reg;
                cy_reg[idx_reg]  <= q_cent;
                sx_reg[idx_reg]  <= '0;
                sy_reg[idx_reg]  <= '0;
                cnt_reg[idx_reg] <= '0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            px_reg     <= coord_x;
            py_reg     <= coord_y;
            dacc_reg   <= '0;
            best_reg   <= '0;
            best_d_reg <= '0;
        end
        if (state_reg == ST_DIST_X)
            dacc_reg <= dsum;
        if (state_reg == ST_DIST_Y)
            dacc_reg <= dsum;
        if (state_reg == ST_COMPARE)
        begin
            dacc_reg <= '0;
            if (idx_reg == '0 || dacc_reg < best_d_reg)
            begin
                best_d_reg <= dacc_reg;
                best_reg   <= idx_reg;
            end
        end
        // Load the divider with the magnitude of the scaled sum.
        if ((state_reg == ST_UPD_START && cnt_reg[idx_reg] != '0) ||
            (state_reg == ST_UPD_WRITE && !axis_reg))
        begin
            drem_reg <= '0;
            if (state_reg == ST_UPD_START)
            begin
                dneg_reg <= sx_reg[idx_reg][SUM_BITS-1];
                dnum_reg <= {(sx_reg[idx_reg][SUM_BITS-1] ? SUM_BITS'(-sx_reg[idx_reg])
                             : sx_reg[idx_reg]), {FRAC_BITS{1'b0}}};
            end
            else
            begin
                dneg_reg <= sel_sum[SUM_BITS-1] == 1'b0 ? sy_reg[idx_reg][SUM_BITS-1]
                            : sy_reg[idx_reg][SUM_BITS-1];
                dnum_reg <= {(sy_reg[idx_reg][SUM_BITS-1] ? SUM_BITS'(-sy_reg[idx_reg])
                             : sy_reg[idx_reg]), {FRAC_BITS{1'b0}}};
                nx_reg   <= q_cent;
            end
        end
        else if (state_reg == ST_DIV && dcnt_reg != DIV_CNT_BITS'(NUM_BITS))
        begin
            drem_reg <= rem_sub;
            dnum_reg <= {dnum_reg[NUM_BITS-2:0], rem_ge};
        end
        // Result word.
        if (state_reg == ST_ACCUM)
        begin
            kind_reg <= 1'b0;
            id_reg   <= 3'(best_reg);
            mv_reg   <= 1'b0;
        end
        if ((state_reg == ST_UPD_START || state_reg == ST_UPD_WRITE) && state_next == ST_OUT)
        begin
            kind_reg <= 1'b1;
            id_reg   <= 3'd0;
            mv_reg   <= moved_reg || (state_reg == ST_UPD_WRITE &&
                        (nx_reg != cx_reg[idx_reg] || q_cent != cy_reg[idx_reg]));
        end
    end

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input ready while busy");
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(kind) && $stable(nearest_id)))
        else $error("result word changed while stalled");
    a_id_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !kind) |-> ((IDX_BITS+1)'(nearest_id) < n_eff))
        else $error("nearest id outside active range");
    a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (dcnt_reg <= DIV_CNT_BITS'(NUM_BITS)))
        else $error("divider ran past its width");
`endif

endmodule
